@@ src/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: the request and
// response item layouts, the request codes and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam logic [3:0] REQ_INS_FRONT  = 4'd0;
    localparam logic [3:0] REQ_INS_BACK   = 4'd1;
    localparam logic [3:0] REQ_INS_AT     = 4'd2;
    localparam logic [3:0] REQ_DEL_FRONT  = 4'd3;
    localparam logic [3:0] REQ_DEL_BACK   = 4'd4;
    localparam logic [3:0] REQ_DEL_AT     = 4'd5;
    localparam logic [3:0] REQ_FIND_FIRST = 4'd6;
    localparam logic [3:0] REQ_FIND_LAST  = 4'd7;
    localparam logic [3:0] REQ_COUNT      = 4'd8;
    localparam logic [3:0] REQ_READ_COUNT = 4'd9;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [4:0]         position;
        logic signed [31:0] value;
    } ple_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_position;
        logic [4:0] match_count;
        logic [4:0] entry_count;
    } ple_rsp_t;

endpackage

`default_nettype wire

@@ src/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed 32-bit values held in one RAM in list
// order. Inserts and deletes at front, back or a 1-based position; searches
// for the first or last match of a key; counts matches; reads the count.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request that walks n stored entries
// reads them in turn, handles the last read-back, finishes, loads the
// response register and returns to idle. n is the entry count for a search
// or match count, the entries from the slot to the end for an insert, and
// the entries after the removed slot for a delete. A walk with nothing to
// move (insert at the back, delete of the last entry, search of an empty
// list) does no reads; a rejected request or a count read skips the walk.
// The walk is paced by the single RAM read port, one entry per cycle, with
// the read-back write overlapped with the next read. A finished response
// sits in an output register, so the next request is accepted while it
// waits to be taken; a request that finishes while that register is still
// full holds until it is taken.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire ple_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output ple_rsp_t      rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [3:0]          code_reg,    code_next;
    logic [31:0]         key_reg,     key_next;
    logic [ADDR_W-1:0]   idx_reg,     idx_next;
    logic [ADDR_W-1:0]   ptr_reg,     ptr_next;
    logic [ADDR_W-1:0]   stop_reg,    stop_next;
    logic                issuing_reg, issuing_next;
    logic                pend_reg,    pend_next;
    logic [ADDR_W-1:0]   paddr_reg,   paddr_next;
    logic [1:0]          status_reg,  status_next;
    logic [CNT_W-1:0]    found_reg,   found_next;
    logic [CNT_W-1:0]    match_reg,   match_next;
    logic                rsp_valid_reg, rsp_valid_next;
    ple_rsp_t            rsp_reg,     rsp_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [31:0]         wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [31:0]         rd_data;

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic              full;
        logic              empty;
        logic [CMP_W-1:0]  pos_ext;
        logic [CMP_W-1:0]  cnt_ext;
        logic [ADDR_W-1:0] last_idx;
        logic [ADDR_W-1:0] pos_idx;
        logic [CNT_W-1:0]  paddr_pos;

        full      = (count_reg == CNT_W'(CAPACITY));
        empty     = (count_reg == '0);
        pos_ext   = CMP_W'(req.position);
        cnt_ext   = CMP_W'(count_reg);
        last_idx  = ADDR_W'(count_reg - CNT_W'(1));
        pos_idx   = ADDR_W'(pos_ext - CMP_W'(1));
        paddr_pos = CNT_W'(paddr_reg) + CNT_W'(1);

        state_next     = state_reg;
        count_next     = count_reg;
        code_next      = code_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        stop_next      = stop_reg;
        issuing_next   = issuing_reg;
        pend_next      = pend_reg;
        paddr_next     = paddr_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    code_next    = req.req_type;
                    key_next     = req.value;
                    status_next  = STAT_OK;
                    found_next   = '0;
                    match_next   = '0;
                    pend_next    = 1'b0;
                    issuing_next = 1'b0;
                    state_next   = ST_DONE;
                    case (req.req_type) inside
                        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT:
                        begin
                            if (req.req_type == REQ_INS_AT &&
                                (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                if (req.req_type == REQ_INS_FRONT)
                                    idx_next = '0;
                                else if (req.req_type == REQ_INS_BACK)
                                    idx_next = ADDR_W'(count_reg);
                                else
                                    idx_next = pos_idx;
                                ptr_next     = last_idx;
                                stop_next    = idx_next;
                                issuing_next = (CNT_W'(idx_next) != count_reg);
                                state_next   = ST_WALK;
                            end
                        end
                        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (req.req_type == REQ_DEL_AT &&
                                     (pos_ext == '0 || pos_ext > cnt_ext))
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                if (req.req_type == REQ_DEL_FRONT)
                                    idx_next = '0;
                                else if (req.req_type == REQ_DEL_BACK)
                                    idx_next = last_idx;
                                else
                                    idx_next = pos_idx;
                                ptr_next     = idx_next + ADDR_W'(1);
                                stop_next    = last_idx;
                                issuing_next = (CNT_W'(idx_next) + CNT_W'(1) < count_reg);
                                state_next   = ST_WALK;
                            end
                        end
                        REQ_FIND_FIRST, REQ_FIND_LAST, REQ_COUNT:
                        begin
                            ptr_next     = '0;
                            stop_next    = last_idx;
                            issuing_next = !empty;
                            state_next   = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // read stage
                if (issuing_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == stop_reg)
                        issuing_next = 1'b0;
                    else if (code_reg inside {REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT})
                        ptr_next = ptr_reg - ADDR_W'(1);
                    else
                        ptr_next = ptr_reg + ADDR_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // data stage
                if (pend_reg)
                begin
                    case (code_reg) inside
                        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = paddr_reg + ADDR_W'(1);
                            wr_data = rd_data;
                        end
                        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = paddr_reg - ADDR_W'(1);
                            wr_data = rd_data;
                        end
                        REQ_FIND_FIRST:
                        begin
                            if (rd_data == key_reg && found_reg == '0)
                                found_next = paddr_pos;
                        end
                        REQ_FIND_LAST:
                        begin
                            if (rd_data == key_reg)
                                found_next = paddr_pos;
                        end
                        REQ_COUNT:
                        begin
                            if (rd_data == key_reg)
                                match_next = match_reg + CNT_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (!issuing_reg && !pend_reg)
                begin
                    case (code_reg) inside
                        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = idx_reg;
                            wr_data    = key_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT:
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status         = status_reg;
                    rsp_next.found_position = 5'(found_reg);
                    rsp_next.match_count    = 5'(match_reg);
                    rsp_next.entry_count    = 5'(count_reg);
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        stop_reg   <= stop_next;
        paddr_reg  <= paddr_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire

@@ bench/ple_checker.sv @@
// ----------------------------------------------------------------------------
// ple_checker
// Watches both channels of the positional list engine. It keeps its own copy
// of the list, works out the response to each accepted request, and compares
// every accepted response field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  ple_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  ple_rsp_t rsp,
    output int       fail_count,
    output int       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] list_mem [CAPACITY];
    int                 list_len;
    ple_rsp_t           rsp_queue [$];
    ple_rsp_t           want;
    int                 rsp_seen;

    initial
    begin
        list_len      = 0;
        rsp_seen      = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic void open_slot(int idx, logic signed [31:0] v);
        for (int i = list_len; i > idx; i--)
            list_mem[i] = list_mem[i - 1];
        list_mem[idx] = v;
        list_len++;
    endfunction

    function automatic void close_slot(int idx);
        for (int i = idx; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i + 1];
        list_len--;
    endfunction

    // applies one request to the list copy and returns its response
    function automatic ple_rsp_t apply_request(ple_req_t r);
        ple_rsp_t o;
        logic     full;
        logic     empty;
        int       pos;
        o     = '0;
        full  = (list_len >= CAPACITY);
        empty = (list_len == 0);
        pos   = int'(r.position);
        o.status = STAT_OK;
        case (r.req_type)
            REQ_INS_FRONT:
                if (full) o.status = STAT_FULL;
                else open_slot(0, r.value);
            REQ_INS_BACK:
                if (full) o.status = STAT_FULL;
                else open_slot(list_len, r.value);
            REQ_INS_AT:
                if (pos < 1 || pos > list_len + 1) o.status = STAT_RANGE;
                else if (full) o.status = STAT_FULL;
                else open_slot(pos - 1, r.value);
            REQ_DEL_FRONT:
                if (empty) o.status = STAT_EMPTY;
                else close_slot(0);
            REQ_DEL_BACK:
                if (empty) o.status = STAT_EMPTY;
                else close_slot(list_len - 1);
            REQ_DEL_AT:
                if (empty) o.status = STAT_EMPTY;
                else if (pos < 1 || pos > list_len) o.status = STAT_RANGE;
                else close_slot(pos - 1);
            REQ_FIND_FIRST:
                for (int i = list_len - 1; i >= 0; i--)
                    if (list_mem[i] == r.value) o.found_position = 5'(i + 1);
            REQ_FIND_LAST:
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == r.value) o.found_position = 5'(i + 1);
            REQ_COUNT:
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == r.value) o.match_count++;
            default:
                ;
        endcase
        o.entry_count = 5'(list_len);
        return o;
    endfunction

    task automatic report(string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                if (rsp_queue.size() == 0)
                    report($sformatf("item %0d: response with no request waiting", rsp_seen));
                else
                begin
                    want = rsp_queue.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("item %0d status: got %0d, expected %0d",
                                         rsp_seen, rsp.status, want.status));
                    if (rsp.found_position !== want.found_position)
                        report($sformatf("item %0d found_position: got %0d, expected %0d",
                                         rsp_seen, rsp.found_position, want.found_position));
                    if (rsp.match_count !== want.match_count)
                        report($sformatf("item %0d match_count: got %0d, expected %0d",
                                         rsp_seen, rsp.match_count, want.match_count));
                    if (rsp.entry_count !== want.entry_count)
                        report($sformatf("item %0d entry_count: got %0d, expected %0d",
                                         rsp_seen, rsp.entry_count, want.entry_count));
                end
            end
            if (req_valid && req_ready)
                rsp_queue.push_back(apply_request(req));
            pending_count = rsp_queue.size();
        end
    end

endmodule

@@ bench/tb_positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Drives the positional list engine with a directed set of edge cases, then
// with random phases that grow, shrink, search and scramble the list, under
// bursty requests and a stalling receiver. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [3:0] REQ_UNUSED_LO = 4'd10;
    localparam logic [3:0] REQ_UNUSED_HI = 4'd15;

    localparam int PHASE_GROW   = 0;
    localparam int PHASE_SHRINK = 1;
    localparam int PHASE_SEARCH = 2;
    localparam int PHASE_NOISE  = 3;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    ple_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ple_rsp_t rsp;

    int       fail_count;
    int       pending_count;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       stall_mode  = 0;
    int       stall_left  = 0;
    logic [7:0] stall_pat = 8'b1011_0010;

    positional_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ple_checker #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: windows of always-ready, light, patterned and heavy stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        stall_pat = {stall_pat[6:0], stall_pat[7]};
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= stall_pat[0];
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send(logic [3:0] op, logic [4:0] pos, logic signed [31:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req       <= '{req_type: op, position: pos, value: val};
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    function automatic ple_req_t make_item(int phase);
        ple_req_t r;
        int       roll;
        int       ins_pct;
        int       del_pct;
        r.position = 5'($urandom_range(1, $urandom_range(1, 17)));
        if ($urandom_range(0, 9) == 0)
            r.position = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0:       r.value = 32'sh8000_0000;
            1:       r.value = 32'sh7FFF_FFFF;
            2:       r.value = -32'sd1;
            3:       r.value = 32'sd0;
            4:       r.value = 32'sd42;
            5, 6:    r.value = $urandom;
            default: r.value = 32'($urandom_range(0, 3));
        endcase
        case (phase)
            PHASE_GROW:   begin ins_pct = 65; del_pct = 15; end
            PHASE_SHRINK: begin ins_pct = 15; del_pct = 65; end
            PHASE_SEARCH: begin ins_pct = 20; del_pct = 20; end
            default:      begin ins_pct = 35; del_pct = 35; end
        endcase
        roll = $urandom_range(0, 99);
        if (phase == PHASE_NOISE && $urandom_range(0, 4) == 0)
            r.req_type = 4'($urandom_range(0, 15));
        else if (roll < ins_pct)
            case ($urandom_range(0, 2))
                0:       r.req_type = REQ_INS_FRONT;
                1:       r.req_type = REQ_INS_BACK;
                default: r.req_type = REQ_INS_AT;
            endcase
        else if (roll < ins_pct + del_pct)
            case ($urandom_range(0, 2))
                0:       r.req_type = REQ_DEL_FRONT;
                1:       r.req_type = REQ_DEL_BACK;
                default: r.req_type = REQ_DEL_AT;
            endcase
        else
            case ($urandom_range(0, 3))
                0:       r.req_type = REQ_FIND_FIRST;
                1:       r.req_type = REQ_FIND_LAST;
                2:       r.req_type = REQ_COUNT;
                default: r.req_type = REQ_READ_COUNT;
            endcase
        return r;
    endfunction

    initial
    begin
        int       items_done;
        int       phase;
        int       phase_len;
        ple_req_t item;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list
        send(REQ_READ_COUNT, 5'd0, 32'sd0);
        send(REQ_FIND_FIRST, 5'd0, 32'sd0);
        send(REQ_COUNT,      5'd0, 32'sd0);
        send(REQ_DEL_FRONT,  5'd0, 32'sd0);
        send(REQ_DEL_BACK,   5'd0, 32'sd0);
        send(REQ_DEL_AT,     5'd3, 32'sd0);
        send(REQ_INS_AT,     5'd0, 32'sd7);
        send(REQ_INS_AT,     5'd2, 32'sd7);
        // build -1, 0, min, max, -1
        send(REQ_INS_AT,     5'd1, 32'sh8000_0000);
        send(REQ_INS_BACK,   5'd0, 32'sh7FFF_FFFF);
        send(REQ_INS_FRONT,  5'd0, -32'sd1);
        send(REQ_INS_AT,     5'd4, -32'sd1);
        send(REQ_INS_AT,     5'd2, 32'sd0);
        send(REQ_FIND_FIRST, 5'd0, -32'sd1);
        send(REQ_FIND_LAST,  5'd0, -32'sd1);
        send(REQ_FIND_FIRST, 5'd0, 32'sd7);
        send(REQ_COUNT,      5'd0, -32'sd1);
        send(REQ_INS_AT,     5'd31, 32'sd9);
        send(REQ_DEL_AT,     5'd0, 32'sd0);
        send(REQ_DEL_AT,     5'd6, 32'sd0);
        send(REQ_DEL_AT,     5'd31, 32'sd0);
        send(REQ_DEL_AT,     5'd3, 32'sd0);
        send(REQ_DEL_FRONT,  5'd0, 32'sd0);
        send(REQ_DEL_BACK,   5'd0, 32'sd0);
        send(REQ_UNUSED_LO,  5'd1, 32'sd1);
        send(REQ_UNUSED_HI,  5'd31, -32'sd1);

        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            phase     = $urandom_range(PHASE_GROW, PHASE_NOISE);
            phase_len = $urandom_range(8, 40);
            for (int k = 0; k < phase_len && items_done < RANDOM_ITEMS; k++)
            begin
                item = make_item(phase);
                send(item.req_type, item.position, item.value);
                if (item.req_type <= REQ_READ_COUNT)
                    items_done++;
            end
        end
        req_valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/ple_pkg.sv
src/ple_ram.sv
src/positional_list_engine.sv
bench/ple_checker.sv
bench/tb_positional_list_engine.sv
